FILE: rtl/bwlp_pkg.sv
// ----------------------------------------------------------------------------
// bwlp_pkg
// Shared constants and types for the six-lane Butterworth low-pass biquad:
// register packing, sample format and the lane control/result bundles.
// ----------------------------------------------------------------------------
package bwlp_pkg;

  localparam int LANES          = 6;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 20;
  localparam int STATE_BITS     = 40;

  // Lane coefficient register layout
  localparam int REG_BITS    = 64;
  localparam int EN_BIT      = 63;
  localparam int CFG_IDX_W   = $clog2(LANES);

  // Control from the top level to every lane
  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  // Result of one lane for the current item
  typedef struct packed {
    logic                          done;
    logic                          ovf;
    logic signed [SAMPLE_BITS-1:0] y;
  } lane_res_t;

endpackage

FILE: rtl/bwlp_lane.sv
// ----------------------------------------------------------------------------
// bwlp_lane
// One direct form II biquad lane. A single signed multiplier is stepped over
// the half-words of the delay values and of the output sum; the products are
// accumulated, rounded, range-checked and saturated over a fixed sequence.
// ----------------------------------------------------------------------------
module bwlp_lane #(
  parameter int STATE_BITS = bwlp_pkg::STATE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bwlp_pkg::lane_ctl_t                    ctl,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [bwlp_pkg::REG_BITS-1:0]          coef,
  output bwlp_pkg::lane_res_t                    res
);

  localparam int SB    = bwlp_pkg::SAMPLE_BITS;
  localparam int F     = bwlp_pkg::COEF_FRAC_BITS;
  localparam int CW    = F + 3;
  localparam int VW    = STATE_BITS + 2;
  localparam int H     = VW / 2;
  localparam int HW    = VW - H;
  localparam int MA_W  = H + 1;
  localparam int PW    = MA_W + CW;
  localparam int ACC_W = STATE_BITS + F + 4;

  localparam logic signed [ACC_W-1:0] HALF_FB  = ACC_W'(1) <<< (F - 1);
  localparam logic signed [ACC_W-1:0] HALF_OUT = ACC_W'(1) <<< (2 * F - 1);
  localparam logic signed [ACC_W-1:0] ST_MAX   = (ACC_W'(1) <<< (STATE_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0] ST_MIN   = -ST_MAX - 1;
  localparam logic signed [ACC_W-1:0] SMP_MAX  = (ACC_W'(1) <<< (SB - 1)) - 1;
  localparam logic signed [ACC_W-1:0] SMP_MIN  = -SMP_MAX - 1;

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;   // d1 low half * a1
  localparam logic [3:0] ST_M1   = 4'd2;   // d1 high half * a1
  localparam logic [3:0] ST_M2   = 4'd3;   // d2 low half * a2
  localparam logic [3:0] ST_M3   = 4'd4;   // d2 high half * a2
  localparam logic [3:0] ST_A3   = 4'd5;   // last feedback partial product
  localparam logic [3:0] ST_RND1 = 4'd6;   // round feedback to F fraction bits
  localparam logic [3:0] ST_W0   = 4'd7;   // new state value, overflow check
  localparam logic [3:0] ST_VSUM = 4'd8;   // w0 + 2*d1 + d2
  localparam logic [3:0] ST_M4   = 4'd9;   // v low half * b0
  localparam logic [3:0] ST_M5   = 4'd10;  // v high half * b0
  localparam logic [3:0] ST_A5   = 4'd11;  // last output partial product
  localparam logic [3:0] ST_RND2 = 4'd12;  // round output to integer
  localparam logic [3:0] ST_SAT  = 4'd13;  // saturate, commit state

  logic [3:0]                    st_r, st_nxt;
  logic signed [STATE_BITS-1:0]  d1_r, d2_r, w0_r;
  logic signed [VW-1:0]          v_r;
  logic signed [SB-1:0]          x_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic                          ovf_r;
  logic signed [SB-1:0]          y_r;
  logic                          flag_r;
  logic                          done_r;

  logic signed [CW-1:0]          a1, a2, b0, mul_c;
  logic signed [VW-1:0]          opnd;
  logic signed [HW-1:0]          opnd_hi;
  logic signed [MA_W-1:0]        mul_a;
  logic signed [PW-1:0]          mul_p;
  logic                          lo_sel;
  logic signed [ACC_W-1:0]       prod_ext, x_ext, w0_full;
  logic                          w0_ovf, sat_hi, sat_lo;

  // Unpack coefficients
  assign a1 = signed'(coef[3*F+2:2*F]);
  assign a2 = signed'({3'b000, coef[2*F-1:F]});
  assign b0 = signed'({3'b000, coef[F-1:0]});

  // Select multiplier operands for the current step
  always_comb begin
    case (st_r)
      ST_M0, ST_M1: begin
        opnd  = VW'(d1_r);
        mul_c = a1;
      end
      ST_M2, ST_M3: begin
        opnd  = VW'(d2_r);
        mul_c = a2;
      end
      default: begin
        opnd  = v_r;
        mul_c = b0;
      end
    endcase
  end

  assign lo_sel  = (st_r == ST_M0) || (st_r == ST_M2) || (st_r == ST_M4);
  assign opnd_hi = opnd[VW-1:H];
  assign mul_a   = lo_sel ? signed'({1'b0, opnd[H-1:0]}) : MA_W'(opnd_hi);
  assign mul_p   = PW'(mul_a) * PW'(mul_c);

  assign prod_ext = ACC_W'(prod_r);
  assign x_ext    = ACC_W'(x_r) <<< F;
  assign w0_full  = x_ext - acc_r;
  assign w0_ovf   = (w0_full > ST_MAX) || (w0_full < ST_MIN);
  assign sat_hi   = acc_r > SMP_MAX;
  assign sat_lo   = acc_r < SMP_MIN;

  // Step sequence
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (ctl.start && coef[bwlp_pkg::EN_BIT]) st_nxt = ST_M0;
      end
      ST_M0:   st_nxt = ST_M1;
      ST_M1:   st_nxt = ST_M2;
      ST_M2:   st_nxt = ST_M3;
      ST_M3:   st_nxt = ST_A3;
      ST_A3:   st_nxt = ST_RND1;
      ST_RND1: st_nxt = ST_W0;
      ST_W0:   st_nxt = ST_VSUM;
      ST_VSUM: st_nxt = ST_M4;
      ST_M4:   st_nxt = ST_M5;
      ST_M5:   st_nxt = ST_A5;
      ST_A5:   st_nxt = ST_RND2;
      ST_RND2: st_nxt = ST_SAT;
      ST_SAT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      done_r <= 1'b0;
      d1_r   <= '0;
      d2_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (ctl.ack) begin
        done_r <= 1'b0;
      end else if ((st_r == ST_IDLE && ctl.start && !coef[bwlp_pkg::EN_BIT]) ||
                   st_r == ST_SAT) begin
        done_r <= 1'b1;
      end
      // Advance the delay line once the output is formed
      if (st_r == ST_SAT) begin
        d2_r <= d1_r;
        d1_r <= w0_r;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (st_r)
      ST_IDLE: begin
        if (ctl.start) begin
          x_r    <= sample;
          y_r    <= sample;
          flag_r <= 1'b0;
        end
      end
      ST_M1:   acc_r <= prod_ext;
      ST_M2:   acc_r <= acc_r + (prod_ext <<< H);
      ST_M3:   acc_r <= acc_r + prod_ext;
      ST_A3:   acc_r <= acc_r + (prod_ext <<< H);
      ST_RND1: acc_r <= (acc_r + HALF_FB) >>> F;
      ST_W0: begin
        ovf_r <= w0_ovf;
        w0_r  <= w0_ovf ? x_ext[STATE_BITS-1:0] : w0_full[STATE_BITS-1:0];
      end
      ST_VSUM: v_r <= VW'(w0_r) + (VW'(d1_r) <<< 1) + VW'(d2_r);
      ST_M5:   acc_r <= prod_ext;
      ST_A5:   acc_r <= acc_r + (prod_ext <<< H);
      ST_RND2: acc_r <= (acc_r + HALF_OUT) >>> (2 * F);
      ST_SAT: begin
        if (sat_hi) begin
          y_r <= SMP_MAX[SB-1:0];
        end else if (sat_lo) begin
          y_r <= SMP_MIN[SB-1:0];
        end else begin
          y_r <= acc_r[SB-1:0];
        end
        flag_r <= ovf_r | sat_hi | sat_lo;
      end
      default: begin
      end
    endcase
  end

  assign res = '{done: done_r, ovf: flag_r, y: y_r};

endmodule

FILE: rtl/bwlp_merge.sv
// ----------------------------------------------------------------------------
// bwlp_merge
// Gathers the lane results once every lane is done, gathers the overflow
// flags into one mask and holds the item in the output register.
// ----------------------------------------------------------------------------
module bwlp_merge (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bwlp_pkg::lane_res_t                     res [bwlp_pkg::LANES],
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic signed [bwlp_pkg::SAMPLE_BITS-1:0] out_y [bwlp_pkg::LANES],
  output logic [bwlp_pkg::LANES-1:0]              out_mask,
  output logic                                    load
);

  localparam int LN = bwlp_pkg::LANES;

  logic                                    out_valid_r;
  logic signed [bwlp_pkg::SAMPLE_BITS-1:0] y_r [LN];
  logic [LN-1:0]                           mask_r;
  logic [LN-1:0]                           done_vec, ovf_vec;

  // Collect lane status
  always_comb begin
    for (int k = 0; k < LN; k++) begin
      done_vec[k] = res[k].done;
      ovf_vec[k]  = res[k].ovf;
    end
  end

  // Take the item when all lanes are done and the output slot is free
  assign load = (&done_vec) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the merged payload
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < LN; k++) begin
        y_r[k] <= res[k].y;
      end
      mask_r <= ovf_vec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_y     = y_r;
  assign out_mask  = mask_r;

endmodule

FILE: rtl/butterworth_lowpass_biquad_lanes_top.sv
// An accepted item reaches out_valid via the lane step sequence, the done flag and the merge
// output register (only the latter two with every lane disabled), later if the output stalls.
// in_ready stays low until an item is merged; each enabled lane steps its single multiplier
// through six half-word products, then rounding and saturation, in a fixed 13-step sequence.
// Reset (rst_n low, synchronous) clears the delay state, disables all lanes
// and empties the output register.
// ----------------------------------------------------------------------------
// butterworth_lowpass_biquad_lanes_top
// Six independent second-order low-pass biquads in direct form II. Each item
// carries one sample per lane; coefficients come from per-lane registers.
// ----------------------------------------------------------------------------
module butterworth_lowpass_biquad_lanes_top #(
  parameter int STATE_BITS = bwlp_pkg::STATE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  in_sample_0,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  in_sample_1,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  in_sample_2,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  in_sample_3,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  in_sample_4,
  input  logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  in_sample_5,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  out_filtered_0,
  output logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  out_filtered_1,
  output logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  out_filtered_2,
  output logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  out_filtered_3,
  output logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  out_filtered_4,
  output logic signed [bwlp_pkg::SAMPLE_BITS-1:0]  out_filtered_5,
  output logic [bwlp_pkg::LANES-1:0]               out_overflow_mask,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [bwlp_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [bwlp_pkg::REG_BITS-1:0]            cfg_data
);

  localparam int LN = bwlp_pkg::LANES;

  logic [bwlp_pkg::REG_BITS-1:0]           coef_r [LN];
  logic                                    busy_r;
  logic                                    in_acc;
  logic                                    load;
  bwlp_pkg::lane_ctl_t                     ctl;
  bwlp_pkg::lane_res_t                     res [LN];
  logic signed [bwlp_pkg::SAMPLE_BITS-1:0] samp [LN];
  logic signed [bwlp_pkg::SAMPLE_BITS-1:0] out_y [LN];
  logic [LN-1:0]                           done_vec, ovf_vec, en_vec;

  assign samp[0] = in_sample_0;
  assign samp[1] = in_sample_1;
  assign samp[2] = in_sample_2;
  assign samp[3] = in_sample_3;
  assign samp[4] = in_sample_4;
  assign samp[5] = in_sample_5;

  // Coefficient registers; writes beyond the lane count are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LN; k++) begin
        coef_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      for (int k = 0; k < LN; k++) begin
        if (cfg_index == bwlp_pkg::CFG_IDX_W'(k)) coef_r[k] <= cfg_data;
      end
    end
  end

  // One item at work at a time
  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
    end else if (load) begin
      busy_r <= 1'b0;
    end
  end

  assign ctl = '{start: in_acc, ack: load};

  // Lanes
  for (genvar g = 0; g < LN; g++) begin : g_lane
    bwlp_lane #(
      .STATE_BITS(STATE_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sample (samp[g]),
      .coef   (coef_r[g]),
      .res    (res[g])
    );
    assign done_vec[g] = res[g].done;
    assign ovf_vec[g]  = res[g].ovf;
    assign en_vec[g]   = coef_r[g][bwlp_pkg::EN_BIT];
  end

  // Merge lane results into the output register
  bwlp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_y     (out_y),
    .out_mask  (out_overflow_mask),
    .load      (load)
  );

  assign out_filtered_0 = out_y[0];
  assign out_filtered_1 = out_y[1];
  assign out_filtered_2 = out_y[2];
  assign out_filtered_3 = out_y[3];
  assign out_filtered_4 = out_y[4];
  assign out_filtered_5 = out_y[5];

  // Enabled lanes run in lockstep: all of them done or none
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    ((done_vec & en_vec) == '0) || ((done_vec & en_vec) == en_vec))
    else $error("enabled lanes finished out of step");

  // No lane result is pending while no item is at work
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (done_vec == '0))
    else $error("lane result pending while idle");

  // A merge releases the lanes and frees the input
  a_merge_release: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (!busy_r && (done_vec == '0)))
    else $error("lanes not released after merge");

  // A disabled lane never raises its flag
  a_disabled_flag: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((ovf_vec & ~en_vec) == '0))
    else $error("flag set on a disabled lane");

endmodule
